[rtl/rtnh_pkg.sv]
package rtnh_pkg;

   localparam int FRAC_BITS = 16;
   localparam int TAG_BITS  = 16;
   localparam int CRD_W     = 32;
   localparam int SML_W     = CRD_W + 1;
   localparam int FX_W      = FRAC_BITS + 1;
   localparam int WIDE_W    = 104;
   localparam int NUM_OPS   = 24;
   localparam int OP_W      = 5;
   localparam int BIT_W     = 6;
   localparam int CNT_W     = 5;

   localparam logic [FX_W-1:0] ONE_FX = FX_W'(1) << FRAC_BITS;

   localparam int CSR_AW = 5;
   localparam logic [2:0] REG_ORG_X = 3'd0;
   localparam logic [2:0] REG_ORG_Y = 3'd1;
   localparam logic [2:0] REG_ORG_Z = 3'd2;
   localparam logic [2:0] REG_DIR_X = 3'd3;
   localparam logic [2:0] REG_DIR_Y = 3'd4;
   localparam logic [2:0] REG_DIR_Z = 3'd5;

   typedef logic signed [SML_W-1:0]  small_type;
   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] v0_x;
      logic signed [CRD_W-1:0] v0_y;
      logic signed [CRD_W-1:0] v0_z;
      logic signed [CRD_W-1:0] v1_x;
      logic signed [CRD_W-1:0] v1_y;
      logic signed [CRD_W-1:0] v1_z;
      logic signed [CRD_W-1:0] v2_x;
      logic signed [CRD_W-1:0] v2_y;
      logic signed [CRD_W-1:0] v2_z;
      logic [TAG_BITS-1:0]     triangle_id;
      logic                    new_query;
   } req_type;

   typedef struct packed {
      logic                hit_now;
      logic                any_hit;
      logic [FX_W-1:0]     nearest_t;
      logic [FX_W-1:0]     nearest_u;
      logic [FX_W-1:0]     nearest_v;
      logic [TAG_BITS-1:0] nearest_triangle;
   } rsp_type;

   // One queued triangle: edges and origin offset, already relative to v0.
   typedef struct packed {
      small_type           e1x;
      small_type           e1y;
      small_type           e1z;
      small_type           e2x;
      small_type           e2y;
      small_type           e2z;
      small_type           tx;
      small_type           ty;
      small_type           tz;
      logic [TAG_BITS-1:0] tag;
      logic                new_query;
   } entry_type;

   typedef struct packed {
      small_type dx;
      small_type dy;
      small_type dz;
   } dir_type;

   // Operand selects for the multiply sequence.
   localparam logic [4:0] SEL_E1X = 5'd0;
   localparam logic [4:0] SEL_E1Y = 5'd1;
   localparam logic [4:0] SEL_E1Z = 5'd2;
   localparam logic [4:0] SEL_E2X = 5'd3;
   localparam logic [4:0] SEL_E2Y = 5'd4;
   localparam logic [4:0] SEL_E2Z = 5'd5;
   localparam logic [4:0] SEL_TX  = 5'd6;
   localparam logic [4:0] SEL_TY  = 5'd7;
   localparam logic [4:0] SEL_TZ  = 5'd8;
   localparam logic [4:0] SEL_DX  = 5'd9;
   localparam logic [4:0] SEL_DY  = 5'd10;
   localparam logic [4:0] SEL_DZ  = 5'd11;
   localparam logic [4:0] SEL_PX  = 5'd12;
   localparam logic [4:0] SEL_PY  = 5'd13;
   localparam logic [4:0] SEL_PZ  = 5'd14;
   localparam logic [4:0] SEL_QX  = 5'd15;
   localparam logic [4:0] SEL_QY  = 5'd16;
   localparam logic [4:0] SEL_QZ  = 5'd17;

   localparam logic [3:0] DST_PX  = 4'd0;
   localparam logic [3:0] DST_PY  = 4'd1;
   localparam logic [3:0] DST_PZ  = 4'd2;
   localparam logic [3:0] DST_QX  = 4'd3;
   localparam logic [3:0] DST_QY  = 4'd4;
   localparam logic [3:0] DST_QZ  = 4'd5;
   localparam logic [3:0] DST_DET = 4'd6;
   localparam logic [3:0] DST_UN  = 4'd7;
   localparam logic [3:0] DST_VN  = 4'd8;
   localparam logic [3:0] DST_TN  = 4'd9;

   typedef struct packed {
      logic [4:0] msel;
      logic [4:0] wsel;
      logic       neg;
      logic       first;
      logic       last;
      logic [3:0] dst;
   } op_type;

   // Multiply-accumulate program: cross products, determinant and numerators.
   function automatic op_type op_entry(input logic [OP_W-1:0] idx);
      op_type r;
      r = '0;
      unique case (idx)
         5'd0:  r = '{SEL_DY,  SEL_E2Z, 1'b0, 1'b1, 1'b0, DST_PX};
         5'd1:  r = '{SEL_DZ,  SEL_E2Y, 1'b1, 1'b0, 1'b1, DST_PX};
         5'd2:  r = '{SEL_DZ,  SEL_E2X, 1'b0, 1'b1, 1'b0, DST_PY};
         5'd3:  r = '{SEL_DX,  SEL_E2Z, 1'b1, 1'b0, 1'b1, DST_PY};
         5'd4:  r = '{SEL_DX,  SEL_E2Y, 1'b0, 1'b1, 1'b0, DST_PZ};
         5'd5:  r = '{SEL_DY,  SEL_E2X, 1'b1, 1'b0, 1'b1, DST_PZ};
         5'd6:  r = '{SEL_E1X, SEL_PX,  1'b0, 1'b1, 1'b0, DST_DET};
         5'd7:  r = '{SEL_E1Y, SEL_PY,  1'b0, 1'b0, 1'b0, DST_DET};
         5'd8:  r = '{SEL_E1Z, SEL_PZ,  1'b0, 1'b0, 1'b1, DST_DET};
         5'd9:  r = '{SEL_TY,  SEL_E1Z, 1'b0, 1'b1, 1'b0, DST_QX};
         5'd10: r = '{SEL_TZ,  SEL_E1Y, 1'b1, 1'b0, 1'b1, DST_QX};
         5'd11: r = '{SEL_TZ,  SEL_E1X, 1'b0, 1'b1, 1'b0, DST_QY};
         5'd12: r = '{SEL_TX,  SEL_E1Z, 1'b1, 1'b0, 1'b1, DST_QY};
         5'd13: r = '{SEL_TX,  SEL_E1Y, 1'b0, 1'b1, 1'b0, DST_QZ};
         5'd14: r = '{SEL_TY,  SEL_E1X, 1'b1, 1'b0, 1'b1, DST_QZ};
         5'd15: r = '{SEL_TX,  SEL_PX,  1'b0, 1'b1, 1'b0, DST_UN};
         5'd16: r = '{SEL_TY,  SEL_PY,  1'b0, 1'b0, 1'b0, DST_UN};
         5'd17: r = '{SEL_TZ,  SEL_PZ,  1'b0, 1'b0, 1'b1, DST_UN};
         5'd18: r = '{SEL_DX,  SEL_QX,  1'b0, 1'b1, 1'b0, DST_VN};
         5'd19: r = '{SEL_DY,  SEL_QY,  1'b0, 1'b0, 1'b0, DST_VN};
         5'd20: r = '{SEL_DZ,  SEL_QZ,  1'b0, 1'b0, 1'b1, DST_VN};
         5'd21: r = '{SEL_E2X, SEL_QX,  1'b0, 1'b1, 1'b0, DST_TN};
         5'd22: r = '{SEL_E2Y, SEL_QY,  1'b0, 1'b0, 1'b0, DST_TN};
         5'd23: r = '{SEL_E2Z, SEL_QZ,  1'b0, 1'b0, 1'b1, DST_TN};
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[rtl/rtnh_front.sv]
module rtnh_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rtnh_pkg::req_type   req_payload,
   input  logic [3*rtnh_pkg::CRD_W-1:0] origin,
   output logic                head_valid,
   output rtnh_pkg::entry_type head,
   input  logic                head_pop
);

   rtnh_pkg::entry_type q_ff [2];
   rtnh_pkg::entry_type q_in;
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic                push;

   function automatic rtnh_pkg::small_type sdiff(input logic signed [rtnh_pkg::CRD_W-1:0] a,
                                                input logic signed [rtnh_pkg::CRD_W-1:0] b);
      return rtnh_pkg::SML_W'(a) - rtnh_pkg::SML_W'(b);
   endfunction

   assign req_ready  = (cnt_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign head_valid = (cnt_ff != 2'd0);
   assign head       = q_ff[rd_ptr_ff];

   always_comb begin
      q_in.e1x = sdiff(req_payload.v1_x, req_payload.v0_x);
      q_in.e1y = sdiff(req_payload.v1_y, req_payload.v0_y);
      q_in.e1z = sdiff(req_payload.v1_z, req_payload.v0_z);
      q_in.e2x = sdiff(req_payload.v2_x, req_payload.v0_x);
      q_in.e2y = sdiff(req_payload.v2_y, req_payload.v0_y);
      q_in.e2z = sdiff(req_payload.v2_z, req_payload.v0_z);
      q_in.tx  = sdiff(origin[3*rtnh_pkg::CRD_W-1:2*rtnh_pkg::CRD_W], req_payload.v0_x);
      q_in.ty  = sdiff(origin[2*rtnh_pkg::CRD_W-1:rtnh_pkg::CRD_W], req_payload.v0_y);
      q_in.tz  = sdiff(origin[rtnh_pkg::CRD_W-1:0], req_payload.v0_z);
      q_in.tag = req_payload.triangle_id;
      q_in.new_query = req_payload.new_query;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = head_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

endmodule

[rtl/rtnh_back.sv]
module rtnh_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  rtnh_pkg::entry_type head,
   output logic                head_pop,
   input  rtnh_pkg::dir_type   dir,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rtnh_pkg::rsp_type   rsp_payload
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LOAD  = 7'b0000010,
      ST_MUL   = 7'b0000100,
      ST_NORM  = 7'b0001000,
      ST_CHECK = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   localparam logic [rtnh_pkg::BIT_W-1:0] LAST_BIT = rtnh_pkg::BIT_W'(rtnh_pkg::SML_W - 1);
   localparam logic [rtnh_pkg::OP_W-1:0]  LAST_OP  = rtnh_pkg::OP_W'(rtnh_pkg::NUM_OPS - 1);
   localparam logic [rtnh_pkg::CNT_W-1:0] LAST_DIV = rtnh_pkg::CNT_W'(rtnh_pkg::FRAC_BITS);
   localparam logic [1:0] DIV_T = 2'd0;
   localparam logic [1:0] DIV_U = 2'd1;
   localparam logic [1:0] DIV_V = 2'd2;

   state_type                       st_ff, st_in;
   rtnh_pkg::entry_type             item_ff, item_in;
   logic [rtnh_pkg::OP_W-1:0]       op_ff, op_in;
   logic [rtnh_pkg::BIT_W-1:0]      bit_ff, bit_in;
   rtnh_pkg::wide_type              acc_ff, acc_in, bsh_ff, bsh_in;
   rtnh_pkg::small_type             mul_ff, mul_in;
   rtnh_pkg::wide_type              px_ff, py_ff, pz_ff, qx_ff, qy_ff, qz_ff;
   rtnh_pkg::wide_type              px_in, py_in, pz_in, qx_in, qy_in, qz_in;
   rtnh_pkg::wide_type              det_ff, un_ff, vn_ff, tn_ff;
   rtnh_pkg::wide_type              det_in, un_in, vn_in, tn_in;
   logic [rtnh_pkg::WIDE_W-1:0]     rem_ff, rem_in;
   logic [rtnh_pkg::FX_W-1:0]       quo_ff, quo_in;
   logic [rtnh_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [1:0]                      dsel_ff, dsel_in;
   logic [rtnh_pkg::FX_W-1:0]       tq_ff, tq_in, uq_ff, uq_in, vq_ff, vq_in;
   logic                            hit_ff, hit_in;
   logic                            seen_ff, seen_in;
   logic [rtnh_pkg::FX_W-1:0]       bt_ff, bt_in, bu_ff, bu_in, bv_ff, bv_in;
   logic [rtnh_pkg::TAG_BITS-1:0]   btag_ff, btag_in;
   logic                            rv_ff, rv_in;
   rtnh_pkg::rsp_type               rsp_ff, rsp_in;

   rtnh_pkg::op_type                op;
   rtnh_pkg::wide_type              wide_opd, term, acc_sum;
   logic                            dge;
   logic [rtnh_pkg::WIDE_W-1:0]     rem_sub;
   logic [rtnh_pkg::FX_W-1:0]       quo_next;
   logic                            seen_eff;
   logic [rtnh_pkg::FX_W-1:0]       bt_eff;
   logic                            ok;
   logic                            out_free;

   function automatic rtnh_pkg::small_type small_sel(input logic [4:0] sel,
                                                    input rtnh_pkg::entry_type it,
                                                    input rtnh_pkg::dir_type d);
      rtnh_pkg::small_type r;
      r = '0;
      unique case (sel)
         rtnh_pkg::SEL_E1X: r = it.e1x;
         rtnh_pkg::SEL_E1Y: r = it.e1y;
         rtnh_pkg::SEL_E1Z: r = it.e1z;
         rtnh_pkg::SEL_E2X: r = it.e2x;
         rtnh_pkg::SEL_E2Y: r = it.e2y;
         rtnh_pkg::SEL_E2Z: r = it.e2z;
         rtnh_pkg::SEL_TX:  r = it.tx;
         rtnh_pkg::SEL_TY:  r = it.ty;
         rtnh_pkg::SEL_TZ:  r = it.tz;
         rtnh_pkg::SEL_DX:  r = d.dx;
         rtnh_pkg::SEL_DY:  r = d.dy;
         rtnh_pkg::SEL_DZ:  r = d.dz;
         default:           r = '0;
      endcase
      return r;
   endfunction

   assign op       = rtnh_pkg::op_entry(op_ff);
   assign out_free = !rv_ff || rsp_ready;
   assign rsp_valid   = rv_ff;
   assign rsp_payload = rsp_ff;
   assign seen_eff = item_ff.new_query ? 1'b0 : seen_ff;
   assign bt_eff   = item_ff.new_query ? rtnh_pkg::ONE_FX : bt_ff;

   always_comb begin
      unique case (op.wsel)
         rtnh_pkg::SEL_PX: wide_opd = px_ff;
         rtnh_pkg::SEL_PY: wide_opd = py_ff;
         rtnh_pkg::SEL_PZ: wide_opd = pz_ff;
         rtnh_pkg::SEL_QX: wide_opd = qx_ff;
         rtnh_pkg::SEL_QY: wide_opd = qy_ff;
         rtnh_pkg::SEL_QZ: wide_opd = qz_ff;
         default: wide_opd = rtnh_pkg::WIDE_W'(small_sel(op.wsel, item_ff, dir));
      endcase
   end

   // Shift-and-add step; the multiplier's top bit carries negative weight.
   always_comb begin
      term    = (bit_ff == LAST_BIT) ? -bsh_ff : bsh_ff;
      acc_sum = mul_ff[0] ? acc_ff + term : acc_ff;
   end

   always_comb begin
      dge      = rem_ff >= $unsigned(det_ff);
      rem_sub  = dge ? rem_ff - $unsigned(det_ff) : rem_ff;
      quo_next = {quo_ff[rtnh_pkg::FX_W-2:0], dge};
   end

   always_comb begin
      ok = (det_ff != '0) && !un_ff[rtnh_pkg::WIDE_W-1] && (det_ff >= un_ff) &&
           !vn_ff[rtnh_pkg::WIDE_W-1] && (det_ff >= un_ff + vn_ff) &&
           !tn_ff[rtnh_pkg::WIDE_W-1] && (det_ff >= tn_ff);
   end

   always_comb begin
      st_in = st_ff;  item_in = item_ff; op_in = op_ff; bit_in = bit_ff;
      acc_in = acc_ff; bsh_in = bsh_ff; mul_in = mul_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      qx_in = qx_ff; qy_in = qy_ff; qz_in = qz_ff;
      det_in = det_ff; un_in = un_ff; vn_in = vn_ff; tn_in = tn_ff;
      rem_in = rem_ff; quo_in = quo_ff; cnt_in = cnt_ff; dsel_in = dsel_ff;
      tq_in = tq_ff; uq_in = uq_ff; vq_in = vq_ff; hit_in = hit_ff;
      seen_in = seen_ff; bt_in = bt_ff; bu_in = bu_ff; bv_in = bv_ff; btag_in = btag_ff;
      rv_in = rv_ff && !rsp_ready;
      rsp_in = rsp_ff;
      head_pop = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               item_in  = head;
               op_in    = '0;
               st_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            mul_in = small_sel(op.msel, item_ff, dir);
            bsh_in = op.neg ? -wide_opd : wide_opd;
            if (op.first) begin
               acc_in = '0;
            end
            bit_in = '0;
            st_in  = ST_MUL;
         end
         ST_MUL: begin
            acc_in = acc_sum;
            bsh_in = bsh_ff <<< 1;
            mul_in = mul_ff >>> 1;
            bit_in = bit_ff + 1'b1;
            if (bit_ff == LAST_BIT) begin
               if (op.last) begin
                  unique case (op.dst)
                     rtnh_pkg::DST_PX:  px_in  = acc_sum;
                     rtnh_pkg::DST_PY:  py_in  = acc_sum;
                     rtnh_pkg::DST_PZ:  pz_in  = acc_sum;
                     rtnh_pkg::DST_QX:  qx_in  = acc_sum;
                     rtnh_pkg::DST_QY:  qy_in  = acc_sum;
                     rtnh_pkg::DST_QZ:  qz_in  = acc_sum;
                     rtnh_pkg::DST_DET: det_in = acc_sum;
                     rtnh_pkg::DST_UN:  un_in  = acc_sum;
                     rtnh_pkg::DST_VN:  vn_in  = acc_sum;
                     rtnh_pkg::DST_TN:  tn_in  = acc_sum;
                     default: ;
                  endcase
               end
               if (op_ff == LAST_OP) begin
                  st_in = ST_NORM;
               end else begin
                  op_in = op_ff + 1'b1;
                  st_in = ST_LOAD;
               end
            end
         end
         ST_NORM: begin
            if (det_ff[rtnh_pkg::WIDE_W-1]) begin
               det_in = -det_ff; un_in = -un_ff; vn_in = -vn_ff; tn_in = -tn_ff;
            end
            st_in = ST_CHECK;
         end
         ST_CHECK: begin
            hit_in  = 1'b0;
            rem_in  = $unsigned(tn_ff);
            quo_in  = '0;
            cnt_in  = '0;
            dsel_in = DIV_T;
            st_in   = ok ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            quo_in = quo_next;
            rem_in = rem_sub << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_DIV) begin
               rem_in = $unsigned(un_ff);
               quo_in = '0;
               cnt_in = '0;
               unique case (dsel_ff)
                  DIV_T: begin
                     tq_in   = quo_next;
                     hit_in  = !seen_eff || (quo_next < bt_eff);
                     dsel_in = DIV_U;
                     st_in   = (!seen_eff || (quo_next < bt_eff)) ? ST_DIV : ST_DONE;
                  end
                  DIV_U: begin
                     uq_in   = quo_next;
                     rem_in  = $unsigned(vn_ff);
                     dsel_in = DIV_V;
                  end
                  default: begin
                     vq_in = quo_next;
                     st_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (out_free) begin
               if (item_ff.new_query) begin
                  seen_in = 1'b0; bt_in = rtnh_pkg::ONE_FX;
                  bu_in = '0; bv_in = '0; btag_in = '0;
               end
               if (hit_ff) begin
                  seen_in = 1'b1; bt_in = tq_ff; bu_in = uq_ff; bv_in = vq_ff;
                  btag_in = item_ff.tag;
               end
               rsp_in.hit_now          = hit_ff;
               rsp_in.any_hit          = seen_in;
               rsp_in.nearest_t        = bt_in;
               rsp_in.nearest_u        = bu_in;
               rsp_in.nearest_v        = bv_in;
               rsp_in.nearest_triangle = btag_in;
               rv_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         rv_ff   <= 1'b0;
         seen_ff <= 1'b0;
         bt_ff   <= rtnh_pkg::ONE_FX;
         bu_ff   <= '0;
         bv_ff   <= '0;
         btag_ff <= '0;
      end else begin
         st_ff   <= st_in;
         rv_ff   <= rv_in;
         seen_ff <= seen_in;
         bt_ff   <= bt_in;
         bu_ff   <= bu_in;
         bv_ff   <= bv_in;
         btag_ff <= btag_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in; op_ff <= op_in; bit_ff <= bit_in;
      acc_ff <= acc_in; bsh_ff <= bsh_in; mul_ff <= mul_in;
      px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
      qx_ff <= qx_in; qy_ff <= qy_in; qz_ff <= qz_in;
      det_ff <= det_in; un_ff <= un_in; vn_ff <= vn_in; tn_ff <= tn_in;
      rem_ff <= rem_in; quo_ff <= quo_in; cnt_ff <= cnt_in; dsel_ff <= dsel_in;
      tq_ff <= tq_in; uq_ff <= uq_in; vq_ff <= vq_in; hit_ff <= hit_in;
      rsp_ff <= rsp_in;
   end

endmodule

[rtl/ray_triangle_nearest_hit.sv]
// Nearest-hit ray segment / triangle tester. Program the segment origin and
// direction (signed Q16.16, t = 1 at origin + direction) over the APB port while
// the block is idle, then stream one triangle per req beat; set new_query on the
// first triangle of a query to forget the kept hit. Each triangle produces one
// rsp beat with hit_now and the nearest hit kept so far (t, u, v in Q1.16, plus
// the triangle's tag); ties keep the earlier triangle. All products are exact
// and the block handles one triangle at a time in its back end: 24 bit-serial
// multiply-accumulate passes share one wide adder, followed by up to three
// restoring divisions on one shared divider. A rejected triangle skips the
// divisions, one that hits but is not nearer than the kept hit stops after the
// t division, and a new nearest hit also divides for u and v. The front end
// edges and queues up to two triangles, and a finished beat waits in the
// output register without holding up the next.
// Registers: 0x00/0x04/0x08 origin x/y/z, 0x0C/0x10/0x14 direction x/y/z.
module ray_triangle_nearest_hit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  rtnh_pkg::req_type            req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output rtnh_pkg::rsp_type            rsp_payload,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [rtnh_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   logic [31:0] org_x_ff, org_y_ff, org_z_ff, dir_x_ff, dir_y_ff, dir_z_ff;
   logic [2:0]  reg_idx;
   logic        wr_en;

   rtnh_pkg::entry_type head;
   logic                head_valid;
   logic                head_pop;
   rtnh_pkg::dir_type   dir;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;

   // Writes to unused addresses are dropped; reads of them return zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff <= '0;
         org_y_ff <= '0;
         org_z_ff <= '0;
         dir_x_ff <= '0;
         dir_y_ff <= '0;
         dir_z_ff <= 32'd65536;
      end else if (wr_en) begin
         unique case (reg_idx)
            rtnh_pkg::REG_ORG_X: org_x_ff <= pwdata;
            rtnh_pkg::REG_ORG_Y: org_y_ff <= pwdata;
            rtnh_pkg::REG_ORG_Z: org_z_ff <= pwdata;
            rtnh_pkg::REG_DIR_X: dir_x_ff <= pwdata;
            rtnh_pkg::REG_DIR_Y: dir_y_ff <= pwdata;
            rtnh_pkg::REG_DIR_Z: dir_z_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         rtnh_pkg::REG_ORG_X: prdata = org_x_ff;
         rtnh_pkg::REG_ORG_Y: prdata = org_y_ff;
         rtnh_pkg::REG_ORG_Z: prdata = org_z_ff;
         rtnh_pkg::REG_DIR_X: prdata = dir_x_ff;
         rtnh_pkg::REG_DIR_Y: prdata = dir_y_ff;
         rtnh_pkg::REG_DIR_Z: prdata = dir_z_ff;
         default:             prdata = '0;
      endcase
   end

   // The direction is sign-extended once here for the multiply sequence.
   assign dir.dx = rtnh_pkg::SML_W'($signed(dir_x_ff));
   assign dir.dy = rtnh_pkg::SML_W'($signed(dir_y_ff));
   assign dir.dz = rtnh_pkg::SML_W'($signed(dir_z_ff));

   rtnh_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .origin      ({org_x_ff, org_y_ff, org_z_ff}),
      .head_valid  (head_valid),
      .head        (head),
      .head_pop    (head_pop)
   );

   rtnh_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .head_pop    (head_pop),
      .dir         (dir),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[test/tb_ray_triangle_nearest_hit.sv]
module tb_ray_triangle_nearest_hit;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [127:0] exact_type;

   // Keeps its own copy of the segment registers and of the kept nearest hit, and
   // works out the beat the block must return for every triangle it accepts.
   class hit_tracker;
      logic signed [31:0]                      ray[6];
      logic                                    seen;
      logic [rtnh_pkg::FX_W-1:0]               best_t;
      logic [rtnh_pkg::FX_W-1:0]               best_u;
      logic [rtnh_pkg::FX_W-1:0]               best_v;
      logic [rtnh_pkg::TAG_BITS-1:0]           best_tag;
      rtnh_pkg::rsp_type                       pending[$];
      int                                      errors;
      int                                      checked;

      function new();
         ray = '{0, 0, 0, 0, 0, 65536};
         forget();
         errors = 0;
         checked = 0;
      endfunction

      function void forget();
         seen = 1'b0;
         best_t = rtnh_pkg::ONE_FX;
         best_u = '0;
         best_v = '0;
         best_tag = '0;
      endfunction

      function exact_type sx(logic signed [31:0] a);
         return a;
      endfunction

      // floor(n * 2^FRAC_BITS / d) for 0 <= n <= d.
      function logic [rtnh_pkg::FX_W-1:0] ratio(exact_type n, exact_type d);
         exact_type q;
         q = (n <<< rtnh_pkg::FRAC_BITS) / d;
         return q[rtnh_pkg::FX_W-1:0];
      endfunction

      function void note(rtnh_pkg::req_type r);
         exact_type e1x, e1y, e1z, e2x, e2y, e2z, tx, ty, tz, dx, dy, dz;
         exact_type px, py, pz, qx, qy, qz, det, un, vn, tn;
         logic [rtnh_pkg::FX_W-1:0] tq;
         rtnh_pkg::rsp_type x;
         logic hit;
         e1x = sx(r.v1_x) - sx(r.v0_x);
         e1y = sx(r.v1_y) - sx(r.v0_y);
         e1z = sx(r.v1_z) - sx(r.v0_z);
         e2x = sx(r.v2_x) - sx(r.v0_x);
         e2y = sx(r.v2_y) - sx(r.v0_y);
         e2z = sx(r.v2_z) - sx(r.v0_z);
         tx = sx(ray[0]) - sx(r.v0_x);
         ty = sx(ray[1]) - sx(r.v0_y);
         tz = sx(ray[2]) - sx(r.v0_z);
         dx = sx(ray[3]);
         dy = sx(ray[4]);
         dz = sx(ray[5]);
         if (r.new_query) forget();
         px = dy * e2z - dz * e2y;
         py = dz * e2x - dx * e2z;
         pz = dx * e2y - dy * e2x;
         det = e1x * px + e1y * py + e1z * pz;
         qx = ty * e1z - tz * e1y;
         qy = tz * e1x - tx * e1z;
         qz = tx * e1y - ty * e1x;
         un = tx * px + ty * py + tz * pz;
         vn = dx * qx + dy * qy + dz * qz;
         tn = e2x * qx + e2y * qy + e2z * qz;
         hit = 1'b0;
         if (det != 0) begin
            // Flip signs so that both windings are tested the same way.
            if (det < 0) begin
               det = -det; un = -un; vn = -vn; tn = -tn;
            end
            if (un >= 0 && un <= det && vn >= 0 && un + vn <= det &&
                tn >= 0 && tn <= det) begin
               tq = ratio(tn, det);
               if (!seen || tq < best_t) begin
                  seen = 1'b1;
                  best_t = tq;
                  best_u = ratio(un, det);
                  best_v = ratio(vn, det);
                  best_tag = r.triangle_id;
                  hit = 1'b1;
               end
            end
         end
         x.hit_now = hit;
         x.any_hit = seen;
         x.nearest_t = best_t;
         x.nearest_u = best_u;
         x.nearest_v = best_v;
         x.nearest_triangle = best_tag;
         pending.push_back(x);
      endfunction

      function void check(rtnh_pkg::rsp_type a);
         rtnh_pkg::rsp_type e;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected rsp beat %p", a);
            return;
         end
         e = pending.pop_front();
         if (a.hit_now !== e.hit_now || a.any_hit !== e.any_hit ||
             a.nearest_t !== e.nearest_t || a.nearest_u !== e.nearest_u ||
             a.nearest_v !== e.nearest_v ||
             a.nearest_triangle !== e.nearest_triangle) begin
            errors++;
            if (errors <= 10)
               $display("rsp %0d mismatch: hit %b/%b any %b/%b t %h/%h u %h/%h v %h/%h tri %h/%h",
                        checked, e.hit_now, a.hit_now, e.any_hit, a.any_hit,
                        e.nearest_t, a.nearest_t, e.nearest_u, a.nearest_u,
                        e.nearest_v, a.nearest_v, e.nearest_triangle, a.nearest_triangle);
         end
      endfunction
   endclass

   localparam int CYCLE_LIMIT = 12000000;
   localparam int ONE = 65536;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   rtnh_pkg::req_type req_payload;
   rtnh_pkg::rsp_type rsp_payload;
   logic psel, penable, pwrite, pready;
   logic [rtnh_pkg::CSR_AW-1:0] paddr;
   logic [31:0] pwdata, prdata;

   hit_tracker sb = new();
   rtnh_pkg::req_type last_tri;
   int cycles = 0;
   bit held_off = 0;

   ray_triangle_nearest_hit dut (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Every rsp beat is checked at the edge where it is taken.
   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) sb.check(rsp_payload);

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   // The receiver stalls at random. Once, after some results have come, it holds
   // off for far longer than the block takes to fill its queue.
   initial begin
      int g;
      rsp_ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!held_off && sb.checked >= 250) begin
            held_off = 1;
            rsp_ready <= 1'b0;
            repeat (6000) @(posedge clock);
         end else begin
            g = gap_len();
            if (g == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               repeat (g - 1) @(posedge clock);
            end
         end
      end
   end

   task automatic csr_write(int idx, logic [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= rtnh_pkg::CSR_AW'(4 * idx);
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sb.ray[idx] = val;
      @(posedge clock);
   endtask

   // The last beat may still be offered after it was taken, so valid drops first.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // Registers are only rewritten once every result is back.
   task automatic set_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
      wait_idle();
      csr_write(rtnh_pkg::REG_ORG_X, ox);
      csr_write(rtnh_pkg::REG_ORG_Y, oy);
      csr_write(rtnh_pkg::REG_ORG_Z, oz);
      csr_write(rtnh_pkg::REG_DIR_X, dx);
      csr_write(rtnh_pkg::REG_DIR_Y, dy);
      csr_write(rtnh_pkg::REG_DIR_Z, dz);
   endtask

   // Offers one triangle, holds it until taken, then idles for a random gap.
   // With no gap the next beat follows at once, so valid never drops.
   task automatic send(rtnh_pkg::req_type r);
      int g;
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      sb.note(r);
      last_tri = r;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Triangle in the plane z = zf (Q16.16) around the z axis, shifted in x;
   // flip swaps the last two vertices to reverse the winding.
   function automatic rtnh_pkg::req_type flat_tri(int zf, int xs, bit flip, int tag, bit nq);
      rtnh_pkg::req_type r;
      r.v0_x = -ONE + xs; r.v0_y = -ONE; r.v0_z = zf;
      r.v1_x = 3 * ONE + xs; r.v1_y = -ONE; r.v1_z = zf;
      r.v2_x = -ONE + xs; r.v2_y = 3 * ONE; r.v2_z = zf;
      if (flip) begin
         r.v1_x = -ONE + xs; r.v1_y = 3 * ONE;
         r.v2_x = 3 * ONE + xs; r.v2_y = -ONE;
      end
      r.triangle_id = rtnh_pkg::TAG_BITS'(tag);
      r.new_query = nq;
      return r;
   endfunction

   function automatic logic [31:0] off(int span);
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   // Mostly triangles placed around a point on the segment, so that hits and near
   // misses are frequent; copies of the last triangle make ties; the rest is noise.
   function automatic rtnh_pkg::req_type random_tri();
      rtnh_pkg::req_type r;
      logic signed [31:0] pt[3];
      int span, sel, tq;
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
         r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, 16'($urandom), 1'($urandom)};
         return r;
      end
      if (sel < 25) begin
         r = last_tri;
         r.triangle_id = rtnh_pkg::TAG_BITS'($urandom);
         r.new_query = 1'b0;
         return r;
      end
      tq = $urandom_range(0, ONE);
      for (int k = 0; k < 3; k++)
         pt[k] = sb.ray[k] + 32'((64'(signed'(sb.ray[k + 3])) * tq) >>> 16);
      span = 1 << $urandom_range(2, 22);
      r.v0_x = pt[0] - span + off(span / 2); r.v0_y = pt[1] - span + off(span / 2);
      r.v0_z = pt[2] + off(span);
      r.v1_x = pt[0] + 2 * span + off(span); r.v1_y = pt[1] - span + off(span / 2);
      r.v1_z = pt[2] + off(span);
      r.v2_x = pt[0] - span + off(span / 2); r.v2_y = pt[1] + 2 * span + off(span);
      r.v2_z = pt[2] + off(span);
      r.triangle_id = rtnh_pkg::TAG_BITS'($urandom);
      r.new_query = ($urandom_range(0, 7) == 0);
      return r;
   endfunction

   initial begin
      rtnh_pkg::req_type r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      last_tri = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, with the segment from the origin to z = 1.0 left at reset.
      send(flat_tri(ONE / 2, 0, 0, 1, 1));        // first hit of a query
      send(flat_tri(3 * ONE / 4, 0, 0, 2, 0));    // farther, kept hit stays
      send(flat_tri(ONE / 2, 0, 0, 3, 0));        // equal t, earlier triangle wins
      send(flat_tri(ONE / 4, 0, 1, 4, 0));        // nearer with reversed winding
      r = flat_tri(ONE / 8, 0, 0, 5, 0);
      r.v1_x = r.v0_x; r.v1_y = r.v0_y; r.v2_x = r.v0_x; r.v2_y = r.v0_y;
      send(r);                                    // degenerate triangle
      send(flat_tri(3 * ONE / 2, 0, 0, 6, 0));    // beyond the segment end
      send(flat_tri(-ONE / 2, 0, 0, 7, 0));       // behind the origin
      send(flat_tri(ONE, 0, 0, 8, 1));            // t exactly 1 with nothing kept
      send(flat_tri(ONE / 2, 5 * ONE, 0, 9, 0));  // misses to the side
      send(flat_tri(ONE / 2, -ONE, 0, 10, 0));    // shifted hit inside, u = 1/2, v = 1/4
      send(flat_tri(ONE / 2, ONE, 1, 11, 1));     // ray through an edge, v = 0
      send(flat_tri(ONE / 2, 0, 0, 16'hFFFF, 1));
      send(flat_tri(ONE / 3, 0, 0, 0, 0));
      r = {{9{32'h7FFFFFFF}}, 16'hFFFF, 1'b1};
      send(r);
      r = {{9{32'h80000000}}, 16'h0000, 1'b0};
      send(r);
      r = {32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
           32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'hA5A5, 1'b0};
      send(r);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            1: set_ray(off(1 << 20), off(1 << 20), off(1 << 20),
                       off(1 << 20), off(1 << 20), off(1 << 20));
            2: set_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                       32'h80000000, 32'h80000000, 32'h80000000);
            3: set_ray(off(1 << 16), off(1 << 16), off(1 << 16), 0, 0, 0);
            4: set_ray(32'h80000000, 32'h80000000, 32'h80000000,
                       32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
            5: set_ray(off(1 << 24), off(1 << 24), off(1 << 24),
                       off(1 << 24), off(1 << 24), off(1 << 24));
            6: set_ray(off(1 << 12), off(1 << 12), off(1 << 12),
                       off(1 << 8), off(1 << 8), off(1 << 8));
            7: set_ray(0, 0, 0, 0, 0, ONE);
            default: ;
         endcase
         for (int n = 0; n < 210; n++) begin
            // Once in the run the sender waits for the block to drain.
            if (phase == 4 && n == 100) begin
               req_valid <= 1'b0;
               while (sb.pending.size() != 0) @(posedge clock);
            end
            send(random_tri());
         end
      end

      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[filelist.f]
rtl/rtnh_pkg.sv
rtl/rtnh_front.sv
rtl/rtnh_back.sv
rtl/ray_triangle_nearest_hit.sv
test/tb_ray_triangle_nearest_hit.sv
